/* hdl/cbs_pkg.sv */
// Shared types and constants of the cubic Bezier subdivider.
// Used by cbs_ctrl, cbs_datapath and cubic_bezier_subdivider_core; no dependencies.
`default_nettype none

package cbs_pkg;

  localparam int DEF_MAX_DEPTH  = 4;
  localparam int DEF_COORD_BITS = 16;

  // depth register: 3-bit code, reset value 3
  localparam int          DEPTH_W     = 3;
  localparam logic [2:0]  DEPTH_RESET = 3'd3;

  // each leaf segment sends its first three control points
  localparam logic [1:0]  EMIT_FIRST = 2'd0;
  localparam logic [1:0]  EMIT_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT1,
    ST_SPLIT2,
    ST_SPLIT3,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       cfg_wr;
    logic       load_in;
    logic       split1;
    logic       split2;
    logic       split3;
    logic       pop;
    logic       emit_load;
    logic       emit_last;
    logic [1:0] emit_sel;
  } cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic lvl_one;
    logic stack_empty;
    logic top_leaf;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/cbs_ctrl.sv */
// Controller of the cubic Bezier subdivider: sequencing state machine and output valid.
// Depends on cbs_pkg; drives cbs_datapath through cbs_pkg::cmd_t.
`default_nettype none

module cbs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire cbs_pkg::sts_t sts,
  output cbs_pkg::cmd_t     cmd
);

  cbs_pkg::state_t state_r, state_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbs_pkg::ST_IDLE;
      idx_r       <= cbs_pkg::EMIT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != cbs_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.cfg_wr    = cfg_valid;
    cmd.emit_sel  = idx_r;
    case (state_r)
      cbs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          idx_nxt     = cbs_pkg::EMIT_FIRST;
          state_nxt   = sts.depth_zero ? cbs_pkg::ST_EMIT : cbs_pkg::ST_SPLIT1;
        end
      end
      cbs_pkg::ST_SPLIT1: begin
        cmd.split1 = 1'b1;
        state_nxt  = cbs_pkg::ST_SPLIT2;
      end
      cbs_pkg::ST_SPLIT2: begin
        cmd.split2 = 1'b1;
        state_nxt  = cbs_pkg::ST_SPLIT3;
      end
      cbs_pkg::ST_SPLIT3: begin
        cmd.split3 = 1'b1;
        state_nxt  = sts.lvl_one ? cbs_pkg::ST_EMIT : cbs_pkg::ST_SPLIT1;
      end
      cbs_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit_load = 1'b1;
          if (idx_r == cbs_pkg::EMIT_LAST) begin
            idx_nxt = cbs_pkg::EMIT_FIRST;
            if (sts.stack_empty) begin
              cmd.emit_last = 1'b1;
              state_nxt     = cbs_pkg::ST_IDLE;
            end else begin
              // resume with the deferred right half
              cmd.pop   = 1'b1;
              state_nxt = sts.top_leaf ? cbs_pkg::ST_EMIT : cbs_pkg::ST_SPLIT1;
            end
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = cbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule

`default_nettype wire

/* hdl/cbs_datapath.sv */
// Datapath of the cubic Bezier subdivider: current segment, halving unit, right-half stack,
// depth register and output word register. Depends on cbs_pkg; commanded by cbs_ctrl.
`default_nettype none

module cbs_datapath #(
  parameter int MAX_DEPTH  = cbs_pkg::DEF_MAX_DEPTH,
  parameter int COORD_BITS = cbs_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cbs_pkg::cmd_t                cmd,
  output cbs_pkg::sts_t                     sts,
  input  wire logic [cbs_pkg::DEPTH_W-1:0]  cfg_subdivision_depth,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  output logic signed [COORD_BITS-1:0]      out_point_x,
  output logic signed [COORD_BITS-1:0]      out_point_y,
  output logic                              out_last_point
);

  localparam int CB  = COORD_BITS;
  localparam int LW  = $clog2(MAX_DEPTH + 1);
  localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef logic signed [CB-1:0] crd_t;

  // (a + b) / 2 rounded toward zero
  function automatic crd_t half(input crd_t a, input crd_t b);
    logic signed [CB:0] s;
    s = {a[CB-1], a} + {b[CB-1], b};
    s = s + {{CB{1'b0}}, s[CB]};
    return s[CB:1];
  endfunction

  logic [cbs_pkg::DEPTH_W-1:0] cfg_depth_r;
  logic [LW-1:0]               depth_eff;
  logic [LW-1:0]               lvl_r;
  logic [LW-1:0]               sp_r;
  logic [LW-1:0]               sp_dec;

  // points are [point][coord], coord 0 is x and 1 is y
  crd_t cur_r  [0:3][0:1];
  crd_t m01_r  [0:1];
  crd_t m12_r  [0:1];
  crd_t m23_r  [0:1];
  crd_t m012_r [0:1];
  crd_t m123_r [0:1];
  crd_t mid    [0:1];
  crd_t stk_r  [0:MAX_DEPTH-1][0:3][0:1];
  logic [LW-1:0] stk_lvl_r [0:MAX_DEPTH-1];

  assign depth_eff = (cfg_depth_r > cbs_pkg::DEPTH_W'(MAX_DEPTH)) ? LW'(MAX_DEPTH)
                                                                  : LW'(cfg_depth_r);
  assign sp_dec    = sp_r - {{(LW-1){1'b0}}, 1'b1};

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mid[c] = half(m012_r[c], m123_r[c]);
    end
  end

  assign sts.depth_zero  = (depth_eff == '0);
  assign sts.lvl_one     = (lvl_r == {{(LW-1){1'b0}}, 1'b1});
  assign sts.stack_empty = (sp_r == '0);
  assign sts.top_leaf    = (stk_lvl_r[sp_dec[SIW-1:0]] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_depth_r <= cbs_pkg::DEPTH_RESET;
      sp_r        <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        cfg_depth_r <= cfg_subdivision_depth;
      end
      if (cmd.load_in) begin
        sp_r <= '0;
      end else if (cmd.split3) begin
        sp_r <= sp_r + {{(LW-1){1'b0}}, 1'b1};
      end else if (cmd.pop) begin
        sp_r <= sp_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_r[0][0] <= in_start_x;
      cur_r[0][1] <= in_start_y;
      cur_r[1][0] <= in_ctrl_a_x;
      cur_r[1][1] <= in_ctrl_a_y;
      cur_r[2][0] <= in_ctrl_b_x;
      cur_r[2][1] <= in_ctrl_b_y;
      cur_r[3][0] <= in_end_x;
      cur_r[3][1] <= in_end_y;
      lvl_r       <= depth_eff;
    end
    if (cmd.split1) begin
      for (int c = 0; c < 2; c++) begin
        m01_r[c] <= half(cur_r[0][c], cur_r[1][c]);
        m12_r[c] <= half(cur_r[1][c], cur_r[2][c]);
        m23_r[c] <= half(cur_r[2][c], cur_r[3][c]);
      end
    end
    if (cmd.split2) begin
      for (int c = 0; c < 2; c++) begin
        m012_r[c] <= half(m01_r[c], m12_r[c]);
        m123_r[c] <= half(m12_r[c], m23_r[c]);
      end
    end
    if (cmd.split3) begin
      // defer the right half, continue with the left half
      for (int c = 0; c < 2; c++) begin
        stk_r[sp_r[SIW-1:0]][0][c] <= mid[c];
        stk_r[sp_r[SIW-1:0]][1][c] <= m123_r[c];
        stk_r[sp_r[SIW-1:0]][2][c] <= m23_r[c];
        stk_r[sp_r[SIW-1:0]][3][c] <= cur_r[3][c];
        cur_r[1][c] <= m01_r[c];
        cur_r[2][c] <= m012_r[c];
        cur_r[3][c] <= mid[c];
      end
      stk_lvl_r[sp_r[SIW-1:0]] <= lvl_r - {{(LW-1){1'b0}}, 1'b1};
      lvl_r                    <= lvl_r - {{(LW-1){1'b0}}, 1'b1};
    end
    if (cmd.pop) begin
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 2; c++) begin
          cur_r[k][c] <= stk_r[sp_dec[SIW-1:0]][k][c];
        end
      end
      lvl_r <= stk_lvl_r[sp_dec[SIW-1:0]];
    end
    if (cmd.emit_load) begin
      out_point_x    <= cur_r[cmd.emit_sel][0];
      out_point_y    <= cur_r[cmd.emit_sel][1];
      out_last_point <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

/* hdl/cubic_bezier_subdivider_core.sv */
// Top level of the cubic Bezier subdivider: joins cbs_ctrl and cbs_datapath.
// Depends on cbs_pkg, cbs_ctrl and cbs_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall): one word holds the four control points of a
//   cubic segment. The word is taken when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall): the segment is halved depth first, left half
//   before right half, and every leaf sends its first three control points, one per
//   word; out_last_point marks the final word of the segment (3 * 2^d words, d = depth).
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write the depth
//   only while the block is idle. Codes above MAX_DEPTH act as MAX_DEPTH.
//   Sequence: one accept, then the halving steps of each level on the shared halving
//   unit, then the output words of each leaf in turn. The first word is ready once the
//   halving has reached the first leaf.
//   The final word sits in the output register while the next segment is accepted.
//   Stall: a stalled output word holds and the sequencer waits in front of it.
//   Reset (rst_n low, synchronous): drop all work in flight, clear out_valid, depth = 3.
`default_nettype none

module cubic_bezier_subdivider_core #(
  parameter int MAX_DEPTH  = cbs_pkg::DEF_MAX_DEPTH,
  parameter int COORD_BITS = cbs_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_ctrl_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_point_x,
  output logic signed [COORD_BITS-1:0]      out_point_y,
  output logic                              out_last_point,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cbs_pkg::DEPTH_W-1:0]  cfg_subdivision_depth
);

  // command and status between the sequencer and the datapath
  cbs_pkg::cmd_t cmd;
  cbs_pkg::sts_t sts;

  // Sequencer: accept, three halving steps per level, three output words per leaf,
  // pop of the deferred right half after every leaf but the last.
  cbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: current segment, halving unit, stack of right halves (one entry per level),
  // depth register and output word register.
  cbs_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_subdivision_depth (cfg_subdivision_depth),
    .in_start_x            (in_start_x),
    .in_start_y            (in_start_y),
    .in_ctrl_a_x           (in_ctrl_a_x),
    .in_ctrl_a_y           (in_ctrl_a_y),
    .in_ctrl_b_x           (in_ctrl_b_x),
    .in_ctrl_b_y           (in_ctrl_b_y),
    .in_end_x              (in_end_x),
    .in_end_y              (in_end_y),
    .out_point_x           (out_point_x),
    .out_point_y           (out_point_y),
    .out_last_point        (out_last_point)
  );

`ifndef SYNTH
  // an accepted segment keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // at most one datapath operation on the current segment per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.split1, cmd.split2, cmd.split3, cmd.pop}))
    else $error("conflicting datapath commands");

  // never pop an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.stack_empty)
    else $error("pop from empty stack");

  // the last word of a segment is loaded only once the stack is drained
  a_last_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && cmd.emit_last) |-> (sts.stack_empty && !cmd.pop))
    else $error("last word flagged with work pending");
`endif

endmodule

`default_nettype wire
